@@ rtl/twl_pkg.sv @@
// Shared types, field widths and verdict codes of the trie word lookup.
package twl_pkg;

   localparam int IndexFieldW       = 12;
   localparam int LetterW           = 8;
   localparam int SiblingW          = 8;
   localparam int DefaultCells      = 4096;
   localparam int DefaultMaxSibling = 255;

   localparam logic       ReqLoad   = 1'b0;
   localparam logic       ReqLetter = 1'b1;
   localparam logic [7:0] EndLetter = 8'd0;

   localparam logic [1:0] VerdictWord      = 2'd0;
   localparam logic [1:0] VerdictPrefix    = 2'd1;
   localparam logic [1:0] VerdictMiss      = 2'd2;
   localparam logic [1:0] VerdictUndecided = 2'd3;

   typedef struct packed {
      logic [LetterW-1:0]     letter;
      logic [IndexFieldW-1:0] child;
      logic                   has_child;
      logic [SiblingW-1:0]    siblings;
   } cell_type;

   typedef struct packed {
      logic                   req_type;
      logic [IndexFieldW-1:0] cell_index;
      logic [LetterW-1:0]     cell_letter;
      logic [IndexFieldW-1:0] cell_child;
      logic                   cell_has_child;
      logic [SiblingW-1:0]    cell_siblings;
      logic [LetterW-1:0]     letter;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] verdict;
   } rsp_payload_type;

endpackage

@@ rtl/twl_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transaction.
interface twl_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/trie_word_lookup.sv @@
// Trie word lookup: top level with the scan sequencer.
// A load first reduces its index in the shared reducer, then writes the cell.
// A letter scans up to 256 cells from the current node; a match with a child then descends.
// A terminator reads the node cell before answering; a settled miss answers without a read.
// Transactions are handled one at a time: requests are taken only while the sequencer is idle.
// Synchronous reset returns the search to the root, undecided; the cell memory is not cleared.
module trie_word_lookup #(
   parameter int CELLS        = twl_pkg::DefaultCells,
   parameter int MAX_SIBLINGS = twl_pkg::DefaultMaxSibling
) (
   input  logic         clock,
   input  logic         reset,
   twl_stream_if.sink   req_chan,
   twl_stream_if.source rsp_chan
);
   import twl_pkg::*;

   localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [IW-1:0] LastIdx = IW'(CELLS - 1);
   // A first cell's count can not exceed the field width anyway.
   localparam int SibCap = (MAX_SIBLINGS < 255) ? MAX_SIBLINGS : 255;
   localparam logic [SiblingW-1:0] SibCapW = SiblingW'(SibCap);

   // Sequencer states
   localparam logic [2:0] StIdle     = 3'd0;
   localparam logic [2:0] StLoadWait = 3'd1;
   localparam logic [2:0] StScan     = 3'd2;
   localparam logic [2:0] StDescend  = 3'd3;
   localparam logic [2:0] StTerm     = 3'd4;
   localparam logic [2:0] StResult   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [IW-1:0]       node_ff, node_in;
   logic [1:0]          held_ff, held_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [SiblingW-1:0] count_ff, count_in;
   logic [SiblingW-1:0] len_ff, len_in;
   logic [LetterW-1:0]  want_ff, want_in;
   cell_type            load_cell_ff, load_cell_in;
   logic [1:0]          verdict_ff, verdict_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_verdict_ff, rsp_verdict_in;

   logic                   accept;
   logic                   mod_start;
   logic [IndexFieldW-1:0] mod_value;
   logic                   mod_done;
   logic [IW-1:0]          mod_result;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   cell_type               rd_data;
   logic                   wr_en;
   logic [SiblingW-1:0]    len_now;
   logic [IW-1:0]          pos_next;

   // Shared reduction unit: folds load indices and child links into the table.
   twl_mod_unit #(
      .CELLS (CELLS),
      .IW    (IW)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (mod_value),
      .done   (mod_done),
      .result (mod_result)
   );

   twl_cell_ram #(
      .CELLS (CELLS),
      .IW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (mod_result),
      .wr_data (load_cell_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Take new transactions only between items; the result register
   // decouples the response side.
   assign req_chan.ready = (state_ff == StIdle);
   assign accept         = req_chan.valid && (state_ff == StIdle);

   // Scan position advances by one and wraps at the end of the table.
   assign pos_next = (pos_ff == LastIdx) ? '0 : pos_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      node_in        = node_ff;
      held_in        = held_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      len_in         = len_ff;
      want_in        = want_ff;
      load_cell_in   = load_cell_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      mod_start      = 1'b0;
      mod_value      = req_chan.payload.cell_index;
      rd_en          = 1'b0;
      rd_addr        = node_ff;
      wr_en          = 1'b0;
      // Only the first cell's count bounds the scan.
      len_now        = len_ff;
      if (count_ff == '0) begin
         len_now = (rd_data.siblings > SibCapW) ? SibCapW : rd_data.siblings;
      end

      // Drop the response once the sink takes it.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (req_chan.payload.req_type == ReqLoad) begin
                  load_cell_in.letter    = req_chan.payload.cell_letter;
                  load_cell_in.child     = req_chan.payload.cell_child;
                  load_cell_in.has_child = req_chan.payload.cell_has_child;
                  load_cell_in.siblings  = req_chan.payload.cell_siblings;
                  mod_start = 1'b1;
                  state_in  = StLoadWait;
               end else begin
                  want_in = req_chan.payload.letter;
                  if (req_chan.payload.letter != EndLetter) begin
                     // After a settled miss, ignore further letters.
                     if (held_ff != VerdictMiss) begin
                        rd_en    = 1'b1;
                        pos_in   = node_ff;
                        count_in = '0;
                        state_in = StScan;
                     end
                  end else if (held_ff == VerdictMiss) begin
                     verdict_in = VerdictMiss;
                     state_in   = StResult;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = StTerm;
                  end
               end
            end
         end
         StLoadWait: begin
            if (mod_done) begin
               wr_en    = 1'b1;
               state_in = StIdle;
            end
         end
         StScan: begin
            len_in = len_now;
            if (rd_data.letter == want_ff) begin
               if (rd_data.has_child) begin
                  mod_start = 1'b1;
                  mod_value = rd_data.child;
                  state_in  = StDescend;
               end else begin
                  held_in  = VerdictMiss;
                  state_in = StIdle;
               end
            end else if (count_ff == len_now) begin
               held_in  = VerdictMiss;
               state_in = StIdle;
            end else begin
               pos_in   = pos_next;
               count_in = count_ff + 1'b1;
               rd_en    = 1'b1;
               rd_addr  = pos_next;
            end
         end
         StDescend: begin
            if (mod_done) begin
               node_in  = mod_result;
               state_in = StIdle;
            end
         end
         StTerm: begin
            verdict_in = (rd_data.letter == EndLetter) ? VerdictWord : VerdictPrefix;
            state_in   = StResult;
         end
         StResult: begin
            // Hold until the result register is free, then return to the root.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               node_in        = '0;
               held_in        = VerdictUndecided;
               state_in       = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         node_ff      <= '0;
         held_ff      <= VerdictUndecided;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff         <= pos_in;
      count_ff       <= count_in;
      len_ff         <= len_in;
      want_ff        <= want_in;
      load_cell_ff   <= load_cell_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.payload.verdict = rsp_verdict_ff;

endmodule

@@ rtl/twl_mod_unit.sv @@
// Shared index reducer: folds a 12-bit cell index into the table depth.
module twl_mod_unit #(
   parameter int CELLS = 4096,
   parameter int IW    = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [11:0]   value,
   output logic          done,
   output logic [IW-1:0] result
);
   import twl_pkg::*;

   localparam int RecipW = 2 * IndexFieldW;
   localparam int ProdW  = RecipW + IndexFieldW;
   // A depth of 4096 or more already holds every 12-bit index.
   localparam bit Fits = (CELLS >= (1 << IndexFieldW));
   // Rounded-up reciprocal: the floor quotient is exact for 12-bit values
   // whenever the depth is above 1 and below 4096.
   localparam logic [RecipW-1:0] Recip =
      RecipW'(((1 << RecipW) + CELLS - 1) / CELLS);
   localparam logic [IndexFieldW-1:0] CellsW = IndexFieldW'(CELLS);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [IndexFieldW-1:0] val_ff, val_in;
   logic [IndexFieldW-1:0] quo_ff, quo_in;
   logic [IW-1:0]          rem_ff, rem_in;
   logic [ProdW-1:0]       prod;
   logic [IndexFieldW-1:0] diff;

   // On start: quotient by reciprocal multiplication, registered with the value.
   // While busy: subtract quotient times depth to get the remainder, then raise done.
   always_comb begin
      busy_in = 1'b0;
      done_in = 1'b0;
      val_in  = val_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      prod    = {{RecipW{1'b0}}, value} * {{IndexFieldW{1'b0}}, Recip};
      diff    = val_ff - quo_ff * CellsW;
      if (start) begin
         busy_in = 1'b1;
         val_in  = value;
         quo_in  = prod[RecipW +: IndexFieldW];
      end else if (busy_ff) begin
         done_in = 1'b1;
         rem_in  = Fits ? IW'(val_ff) : IW'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule

@@ rtl/twl_cell_ram.sv @@
// Trie cell memory: one write port and one registered read port.
module twl_cell_ram #(
   parameter int CELLS = 4096,
   parameter int IW    = 12
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IW-1:0]      wr_addr,
   input  twl_pkg::cell_type  wr_data,
   input  logic               rd_en,
   input  logic [IW-1:0]      rd_addr,
   output twl_pkg::cell_type  rd_data
);
   import twl_pkg::*;

   cell_type mem [CELLS];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
